// ===== hdl/sdpg_pkg.sv =====
package sdpg_pkg;

    // sizing of the step counter and the phase timer
    localparam int STEP_COUNT_BITS = 32;
    localparam int TIMER_BITS      = 16;
    localparam logic [31:0] TIMER_MASK = 32'hFFFF_FFFF >> (32 - TIMER_BITS);

    // configuration port
    localparam int PADDR_BITS = 3;
    localparam logic REG_SETTLE  = 1'b0;
    localparam logic REG_RELEASE = 1'b1;
    localparam logic [15:0] SETTLE_RESET  = 16'd2000;
    localparam logic [15:0] RELEASE_RESET = 16'd10;

    // request commands
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_SPEED = 2'd2;
    localparam logic [1:0] CMD_LIMIT = 2'd3;

    // move phases
    localparam logic [2:0] PH_IDLE       = 3'd0;
    localparam logic [2:0] PH_SETTLE_ON  = 3'd1;
    localparam logic [2:0] PH_RUN_HIGH   = 3'd2;
    localparam logic [2:0] PH_RUN_LOW    = 3'd3;
    localparam logic [2:0] PH_SETTLE_OFF = 3'd4;
    localparam logic [2:0] PH_RELEASE    = 3'd5;

    // limit sides and end codes
    localparam logic [1:0] SIDE_NONE = 2'd0;
    localparam logic [1:0] SIDE_ONE  = 2'd1;
    localparam logic [1:0] SIDE_TWO  = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic        move_direction;
        logic [31:0] move_steps;
        logic [7:0]  speed_units;
        logic [1:0]  limit_sensor;
    } t_req;

    typedef struct packed {
        logic        pulse_out;
        logic        dir_out;
        logic        enable_out;
        logic        relay_out;
        logic        busy_res;
        logic        report_valid;
        logic [31:0] report_steps;
        logic [1:0]  report_sensor;
        logic        report_direction;
        logic [1:0]  report_end;
        logic        move_refused;
    } t_res;

    typedef struct packed {
        logic [15:0] settle_delay_ticks;
        logic [15:0] release_delay_ticks;
    } t_cfg;

    // clamp a delay load to the timer range
    function automatic logic [TIMER_BITS-1:0] sat_timer(input logic [31:0] v);
        logic [31:0] c;
        c = (v > TIMER_MASK) ? TIMER_MASK : v;
        return c[TIMER_BITS-1:0];
    endfunction

endpackage

// ===== hdl/sdpg_core.sv =====
module sdpg_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_fire,
    input  sdpg_pkg::t_req i_req,
    input  sdpg_pkg::t_cfg i_cfg,
    output sdpg_pkg::t_res o_res
);
    import sdpg_pkg::*;

    logic [2:0]                 r_phase,           n_phase;
    logic [STEP_COUNT_BITS-1:0] r_steps_left,      n_steps_left;
    logic [STEP_COUNT_BITS-1:0] r_steps_requested, n_steps_requested;
    logic [TIMER_BITS-1:0]      r_phase_timer,     n_phase_timer;
    logic [7:0]                 r_current_speed,   n_current_speed;
    logic [7:0]                 r_pulse_half,      n_pulse_half;
    logic                       r_move_dir,        n_move_dir;
    logic [1:0]                 r_limit_side,      n_limit_side;
    logic [1:0]                 r_end_code,        n_end_code;
    logic                       r_aborted,         n_aborted;

    logic                       done;
    logic                       refused;
    logic                       relay_now;
    logic [STEP_COUNT_BITS-1:0] steps_dec;
    logic [STEP_COUNT_BITS-1:0] steps_for_test;
    logic [STEP_COUNT_BITS-1:0] steps_done;

    assign steps_dec = r_steps_left - STEP_COUNT_BITS'(1);
    assign relay_now = (r_phase >= PH_SETTLE_ON) && (r_phase <= PH_SETTLE_OFF);

    // state update for one request
    always_comb begin
        n_phase           = r_phase;
        n_steps_left      = r_steps_left;
        n_steps_requested = r_steps_requested;
        n_phase_timer     = r_phase_timer;
        n_current_speed   = r_current_speed;
        n_pulse_half      = r_pulse_half;
        n_move_dir        = r_move_dir;
        n_limit_side      = r_limit_side;
        n_end_code        = r_end_code;
        n_aborted         = r_aborted;
        done              = 1'b0;
        refused           = 1'b0;
        steps_for_test    = (r_phase == PH_RUN_LOW) ? steps_dec : r_steps_left;

        case (i_req.cmd)
            CMD_TICK: begin
                if (r_phase == PH_IDLE || r_phase > PH_RELEASE) begin
                    n_phase = PH_IDLE;
                end else if (r_phase_timer > TIMER_BITS'(1)) begin
                    n_phase_timer = r_phase_timer - TIMER_BITS'(1);
                end else begin
                    case (r_phase)
                        PH_SETTLE_ON, PH_RUN_LOW: begin
                            n_steps_left = steps_for_test;
                            // next pulse or wind down
                            if (steps_for_test != '0 && !r_aborted &&
                                r_current_speed != 8'd0) begin
                                n_pulse_half  = r_current_speed;
                                n_phase_timer = sat_timer(32'(r_current_speed));
                                n_phase       = PH_RUN_HIGH;
                            end else begin
                                n_phase_timer = sat_timer(32'(i_cfg.settle_delay_ticks));
                                n_phase       = PH_SETTLE_OFF;
                            end
                        end
                        PH_RUN_HIGH: begin
                            n_phase_timer = sat_timer(32'(r_pulse_half));
                            n_phase       = PH_RUN_LOW;
                        end
                        PH_SETTLE_OFF: begin
                            if (!r_aborted) begin
                                n_limit_side = SIDE_NONE;
                            end
                            n_phase_timer = sat_timer(32'(i_cfg.release_delay_ticks));
                            n_phase       = PH_RELEASE;
                        end
                        default: begin
                            n_phase_timer = '0;
                            n_phase       = PH_IDLE;
                            done          = 1'b1;
                        end
                    endcase
                end
            end
            CMD_START: begin
                if (r_phase == PH_IDLE) begin
                    // direction interlock against the remembered side
                    if ((r_limit_side == SIDE_ONE && !i_req.move_direction) ||
                        (r_limit_side == SIDE_TWO && i_req.move_direction)) begin
                        refused = 1'b1;
                    end else begin
                        n_aborted         = 1'b0;
                        n_move_dir        = i_req.move_direction;
                        n_steps_left      = i_req.move_steps[STEP_COUNT_BITS-1:0];
                        n_steps_requested = i_req.move_steps[STEP_COUNT_BITS-1:0];
                        n_current_speed   = i_req.speed_units;
                        n_phase_timer     = sat_timer(32'(i_cfg.settle_delay_ticks));
                        n_phase           = PH_SETTLE_ON;
                    end
                end
            end
            CMD_SPEED: begin
                n_current_speed = i_req.speed_units;
            end
            default: begin
                // limit event acts only while moving with the relay on
                if (relay_now && r_current_speed != 8'd0 &&
                    i_req.limit_sensor != 2'd0) begin
                    n_limit_side = (i_req.limit_sensor == 2'd1) ? SIDE_ONE : SIDE_TWO;
                    n_end_code   = n_limit_side;
                    n_aborted    = 1'b1;
                end
            end
        endcase
    end

    assign steps_done = n_steps_requested - n_steps_left;

    // result from the updated state
    always_comb begin
        o_res              = '0;
        o_res.pulse_out    = (n_phase == PH_RUN_HIGH);
        o_res.dir_out      = n_move_dir;
        o_res.enable_out   = (n_phase != PH_IDLE);
        o_res.relay_out    = (n_phase >= PH_SETTLE_ON) && (n_phase <= PH_SETTLE_OFF);
        o_res.busy_res     = (n_phase != PH_IDLE);
        if (done || refused) begin
            o_res.report_valid     = done;
            o_res.report_steps     = done ? 32'(steps_done) : 32'd0;
            o_res.report_sensor    = n_limit_side;
            o_res.report_direction = n_move_dir;
            o_res.report_end       = n_end_code;
            o_res.move_refused     = refused;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase           <= PH_IDLE;
            r_steps_left      <= '0;
            r_steps_requested <= '0;
            r_phase_timer     <= '0;
            r_current_speed   <= '0;
            r_pulse_half      <= '0;
            r_move_dir        <= 1'b0;
            r_limit_side      <= SIDE_NONE;
            r_end_code        <= SIDE_NONE;
            r_aborted         <= 1'b0;
        end else if (i_fire) begin
            r_phase           <= n_phase;
            r_steps_left      <= n_steps_left;
            r_steps_requested <= n_steps_requested;
            r_phase_timer     <= n_phase_timer;
            r_current_speed   <= n_current_speed;
            r_pulse_half      <= n_pulse_half;
            r_move_dir        <= n_move_dir;
            r_limit_side      <= n_limit_side;
            r_end_code        <= n_end_code;
            r_aborted         <= n_aborted;
        end
    end

endmodule

// ===== hdl/step_dir_pulse_gen_limit_interlock.sv =====
// Step/direction pulse sequencer with limit-switch direction interlock.
// Input channel (i_in_valid / o_in_ready / i_in_data) carries one request per
// item: a 100 us tick, a start move, a speed update or a limit event.
// Output channel (o_out_valid / i_out_ready / o_out_data) returns exactly one
// result per request: pin levels after the update, plus a report when a move
// finishes or a start is refused by the interlock.
// An accepted request is held in the input register, then is applied to the
// sequencer state while its result is written into the result register,
// and the result is valid from then on.
// Throughput: one request per cycle while results are taken; each request
// is one update of the phase, timer and step counters between both registers.
// When the receiver stalls the result register holds, the input register
// fills, and o_in_ready drops until the result is taken.
// Reset (synchronous, active low) empties both registers, returns the
// sequencer to idle with no remembered limit, and sets the settle delay to
// 2000 ticks and the release delay to 10 ticks.
// The APB port writes the two delay registers (0x0 settle, 0x4 release);
// write them only while no move is in progress.
module step_dir_pulse_gen_limit_interlock (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  sdpg_pkg::t_req                   i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output sdpg_pkg::t_res                   o_out_data,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sdpg_pkg::PADDR_BITS-1:0]  paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import sdpg_pkg::*;

    logic r_in_valid;
    t_req r_in;
    logic r_out_valid;
    t_res r_out;
    t_cfg r_cfg;
    t_res res;
    logic fire;
    logic out_free;
    logic cfg_wr;

    // pipeline handshake
    assign out_free   = !r_out_valid || i_out_ready;
    assign fire       = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    sdpg_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_req   (r_in),
        .i_cfg   (r_cfg),
        .o_res   (res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // configuration registers
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.settle_delay_ticks  <= SETTLE_RESET;
            r_cfg.release_delay_ticks <= RELEASE_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_SETTLE) begin
                r_cfg.settle_delay_ticks <= pwdata[15:0];
            end else begin
                r_cfg.release_delay_ticks <= pwdata[15:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_RELEASE) ? {16'd0, r_cfg.release_delay_ticks}
                                              : {16'd0, r_cfg.settle_delay_ticks};
    assign pready = 1'b1;

endmodule

// ===== hdl/sdpg_chk.sv =====
module sdpg_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input sdpg_pkg::t_res o_out_data
);
    import sdpg_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // a finished move and a refused start never share one result
    a_one_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.report_valid && o_out_data.move_refused))
        else $error("report and refusal together");

    // pin nesting: pulse inside relay, relay inside enable, enable equals busy
    a_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_out_data.pulse_out || o_out_data.relay_out) &&
                        (!o_out_data.relay_out || o_out_data.enable_out) &&
                        (o_out_data.enable_out == o_out_data.busy_res))
        else $error("pin levels inconsistent");

    // report fields are clear when nothing is reported
    a_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.report_valid && !o_out_data.move_refused |->
            o_out_data.report_steps == 32'd0 && o_out_data.report_sensor == 2'd0 &&
            !o_out_data.report_direction && o_out_data.report_end == 2'd0)
        else $error("report fields set without a report");

    // a finished move leaves the block idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.report_valid |-> !o_out_data.busy_res)
        else $error("busy after move report");

endmodule

bind step_dir_pulse_gen_limit_interlock sdpg_chk u_sdpg_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
